// ===== src/cmac_pkg.sv =====
// shared types, constants and aes helper functions for the cmac tag engine
package cmac_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 128;
    localparam int FILL_W      = 5;
    localparam int HALF_W      = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int AES_ROUNDS  = 10;
    localparam int RND_W       = 4;
    localparam int CMAC_QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] GF_POLY  = 8'h87;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

    // kind of block handed from the front to the back
    typedef enum logic [1:0] {
        CMD_CHAIN      = 2'd0,
        CMD_FINAL_FULL = 2'd1,
        CMD_FINAL_PAD  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BLOCK_W-1:0] blk;
    } cmd_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_RUN  = 2'd1,
        BK_FIN  = 2'd2
    } back_state_t;

    typedef enum logic [1:0] {
        MODE_CHAIN  = 2'd0,
        MODE_SUBKEY = 2'd1,
        MODE_FINAL  = 2'd2
    } run_mode_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] v, input int i);
        get_byte = v[BLOCK_W-1-8*i -: 8];
    endfunction

    // one aes round: subbytes, shiftrows, mixcolumns unless last round
    function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                     input logic last_rnd);
        logic [7:0] t [BLOCK_BYTES];
        logic [7:0] a0, a1, a2, a3, all_x;
        logic [BLOCK_W-1:0] r;
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++) begin
                t[rr + 4*c] = SBOX[get_byte(s, rr + 4*((c + rr) & 3))];
            end
        end
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                all_x = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all_x ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all_x ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all_x ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all_x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            r[BLOCK_W-1-8*i -: 8] = t[i];
        end
        aes_round = r;
    endfunction

    // next round key from the previous one
    function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] k,
                                                    input logic [7:0] rcon);
        logic [31:0] tw, w0, w1, w2, w3;
        tw = {SBOX[get_byte(k, 13)] ^ rcon, SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ tw;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

    // doubling in gf(2^128)
    function automatic logic [BLOCK_W-1:0] gf_double(input logic [BLOCK_W-1:0] v);
        gf_double = {v[BLOCK_W-2:0], 1'b0} ^ {{(BLOCK_W-8){1'b0}}, (v[BLOCK_W-1] ? GF_POLY : 8'h00)};
    endfunction

endpackage

// ===== src/cmac_front.sv =====
// front end: packs message bytes into blocks and classifies them for the back end
module cmac_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic                    in_none,
    output logic                    push,
    output cmac_pkg::cmd_t          push_cmd,
    input  logic                    q_full
);
    import cmac_pkg::*;

    logic [BLOCK_W-1:0] buf_reg, buf_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               pend_reg, pend_next;
    cmd_t               pend_cmd_reg, pend_cmd_next;
    logic               accept;

    assign in_ready = !pend_reg && !q_full;
    assign accept   = in_valid && in_ready;

    // byte placement, chain and final hand-off
    always_comb begin
        logic [BLOCK_W-1:0] wbuf;
        logic [FILL_W-1:0]  wfill;
        logic               chain_push;
        cmd_t               fin;
        buf_next      = buf_reg;
        fill_next     = fill_reg;
        pend_next     = pend_reg;
        pend_cmd_next = pend_cmd_reg;
        push          = 1'b0;
        push_cmd      = pend_cmd_reg;
        wbuf          = buf_reg;
        wfill         = fill_reg;
        chain_push    = 1'b0;
        fin           = pend_cmd_reg;
        if (pend_reg) begin
            if (!q_full) begin
                push      = 1'b1;
                pend_next = 1'b0;
            end
        end else if (accept) begin
            if (!in_none) begin
                if (fill_reg == FILL_W'(BLOCK_BYTES)) begin
                    chain_push = 1'b1;
                    wfill      = '0;
                end
                for (int i = 0; i < BLOCK_BYTES; i++) begin
                    if (wfill[3:0] == 4'(i)) wbuf[BLOCK_W-1-8*i -: 8] = in_byte;
                end
                wfill = wfill + 1'b1;
            end
            if (chain_push) begin
                push     = 1'b1;
                push_cmd = '{kind: CMD_CHAIN, blk: buf_reg};
            end
            if (in_last) begin
                if (wfill == FILL_W'(BLOCK_BYTES)) begin
                    fin = '{kind: CMD_FINAL_FULL, blk: wbuf};
                end else begin
                    fin.kind = CMD_FINAL_PAD;
                    for (int i = 0; i < BLOCK_BYTES; i++) begin
                        if (FILL_W'(i) < wfill)
                            fin.blk[BLOCK_W-1-8*i -: 8] = wbuf[BLOCK_W-1-8*i -: 8];
                        else if (FILL_W'(i) == wfill)
                            fin.blk[BLOCK_W-1-8*i -: 8] = PAD_BYTE;
                        else
                            fin.blk[BLOCK_W-1-8*i -: 8] = 8'h00;
                    end
                end
                if (chain_push) begin
                    pend_next     = 1'b1;
                    pend_cmd_next = fin;
                end else begin
                    push     = 1'b1;
                    push_cmd = fin;
                end
                fill_next = '0;
            end else begin
                fill_next = wfill;
                buf_next  = wbuf;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        buf_reg      <= buf_next;
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

// ===== src/cmac_queue.sv =====
// short block queue between front and back end
module cmac_queue #(
    parameter int QUEUE_DEPTH = cmac_pkg::CMAC_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cmac_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop,
    output cmac_pkg::cmd_t pop_cmd
);
    import cmac_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign pop_cmd   = mem[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== src/cmac_back.sv =====
// back end: key registers, subkeys, iterative aes round unit and tag output
module cmac_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    output logic                             cmd_pop,
    input  cmac_pkg::cmd_t                   cmd,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cmac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmac_pkg::HALF_W-1:0]      cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cmac_pkg::BLOCK_W-1:0]     m_tdata
);
    import cmac_pkg::*;

    back_state_t        state_reg, state_next;
    run_mode_t          mode_reg, mode_next;
    logic [HALF_W-1:0]  key_hi_reg, key_lo_reg;
    logic [BLOCK_W-1:0] key;
    logic [BLOCK_W-1:0] chain_reg, chain_next;
    logic [BLOCK_W-1:0] k1_reg, k1_next, k2_reg, k2_next;
    logic               ready_reg, ready_next;
    logic [BLOCK_W-1:0] st_reg, st_next, rk_reg, rk_next;
    logic [7:0]         rcon_reg, rcon_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               outv_reg, outv_next;
    logic [BLOCK_W-1:0] outd_reg, outd_next;
    logic               is_final, out_free, key_wr;
    logic [BLOCK_W-1:0] nrk, fin_in, l_dbl;

    assign key       = {key_hi_reg, key_lo_reg};
    assign cfg_ready = 1'b1;
    assign key_wr    = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
    assign is_final  = (cmd.kind != CMD_CHAIN);
    assign out_free  = !outv_reg || m_tready;
    assign m_tvalid  = outv_reg;
    assign m_tdata   = outd_reg;
    assign nrk       = key_step(rk_reg, rcon_reg);
    assign l_dbl     = gf_double(st_next);
    assign fin_in    = cmd.blk ^ chain_reg ^ ((cmd.kind == CMD_FINAL_FULL) ? k1_reg : k2_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (cmd_valid) state_next = BK_RUN;
            BK_RUN: begin
                if (rnd_reg == RND_W'(AES_ROUNDS))
                    state_next = (mode_reg == MODE_FINAL) ? BK_FIN : BK_IDLE;
            end
            BK_FIN:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_pop    = 1'b0;
        mode_next  = mode_reg;
        chain_next = chain_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        ready_next = ready_reg;
        st_next    = st_reg;
        rk_next    = rk_reg;
        rcon_next  = rcon_reg;
        rnd_next   = rnd_reg;
        outv_next  = outv_reg && !m_tready;
        outd_next  = outd_reg;
        unique case (state_reg)
            BK_IDLE: begin
                rk_next   = key;
                rcon_next = RCON_FIRST;
                rnd_next  = RND_W'(1);
                if (cmd_valid) begin
                    if (!is_final) begin
                        cmd_pop   = 1'b1;
                        mode_next = MODE_CHAIN;
                        st_next   = cmd.blk ^ chain_reg ^ key;
                    end else if (!ready_reg) begin
                        mode_next = MODE_SUBKEY;
                        st_next   = key;
                    end else begin
                        cmd_pop   = 1'b1;
                        mode_next = MODE_FINAL;
                        st_next   = fin_in ^ key;
                    end
                end
            end
            BK_RUN: begin
                st_next   = aes_round(st_reg, rnd_reg == RND_W'(AES_ROUNDS)) ^ nrk;
                rk_next   = nrk;
                rcon_next = xtime(rcon_reg);
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(AES_ROUNDS)) begin
                    if (mode_reg == MODE_CHAIN) chain_next = st_next;
                    if (mode_reg == MODE_SUBKEY) begin
                        k1_next    = l_dbl;
                        k2_next    = gf_double(l_dbl);
                        ready_next = 1'b1;
                    end
                end
            end
            BK_FIN: begin
                if (out_free) begin
                    outv_next  = 1'b1;
                    outd_next  = {st_reg[63:0], st_reg[127:64]};
                    chain_next = '0;
                end
            end
            default: ;
        endcase
        if (key_wr) ready_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            mode_reg   <= MODE_CHAIN;
            chain_reg  <= '0;
            ready_reg  <= 1'b0;
            outv_reg   <= 1'b0;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            chain_reg <= chain_next;
            ready_reg <= ready_next;
            outv_reg  <= outv_next;
            if (cfg_valid && cfg_index == REG_KEY_HIGH) key_hi_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_KEY_LOW)  key_lo_reg <= cfg_data;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        st_reg   <= st_next;
        rk_reg   <= rk_next;
        rcon_reg <= rcon_next;
        rnd_reg  <= rnd_next;
        outd_reg <= outd_next;
    end

endmodule

// ===== src/aes_cmac_tag_engine_top.sv =====
// AES-128 CMAC tag engine: one message byte per transfer in, one 128-bit tag per message
// out. The front end takes a byte every cycle unless a final block waits to enter the
// queue or the queue is full, and packs 16-byte blocks; blocks pass through a short
// queue to a back end whose AES unit runs one round per cycle after a load step. The
// final block of a message is run the same way; the first time after reset or a key
// write the subkeys are derived before it, and the tag is then placed in the output
// register. A long message streams at one byte per cycle, since the back end finishes a
// block before the front end has packed the next. A message shorter than 12 bytes ends
// before its tag is done, so a run of such messages fills the queue and stalls the
// input. With the back end free, the tag follows the last byte once the final block,
// the subkey derivation if due, and any full block released by that last byte have
// run; a backlog of blocks in the queue adds to this. s_tlast ends a message; s_tuser
// marks a transfer that carries no byte. Key writes are taken at any time but belong
// in idle periods.
module aes_cmac_tag_engine_top #(
    parameter int QUEUE_DEPTH = cmac_pkg::CMAC_QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] msg_byte
    input  logic                            s_tlast,
    input  logic                            s_tuser,   // [0] no_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmac_pkg::BLOCK_W-1:0]    m_tdata,   // [63:0] tag_high, [127:64] tag_low
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cmac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmac_pkg::HALF_W-1:0]     cfg_data
);
    import cmac_pkg::*;

    logic push, q_full, q_valid, q_pop;
    cmd_t push_cmd, q_cmd;

    cmac_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .in_none  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    cmac_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_cmd)
    );

    cmac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/aes_cmac_tag_engine_chk.sv =====
// port-level checker for the cmac tag engine, bound to the top level
module aes_cmac_tag_engine_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    // a stalled tag transfer stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("tag dropped while stalled");

    // a stalled tag keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("tag changed while stalled");

    // reset leaves no tag pending
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("tag offered right after reset");

    // reset leaves the queue empty, so the input side is open
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind aes_cmac_tag_engine_top aes_cmac_tag_engine_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
